>>> rtl/srar_pkg.sv
// Shared constants, types and codes for the stride/reuse adaptive replacement block.
package srar_pkg;

  localparam int NUM_SETS = 2048;
  localparam int NUM_WAYS = 16;
  localparam int PC_HISTORY_DEPTH = 16;

  localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int PTR_W = (PC_HISTORY_DEPTH > 1) ? $clog2(PC_HISTORY_DEPTH) : 1;
  localparam int TALLY_W = 9;
  localparam int CFG_W = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_RUN_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MISS_RATE_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_LENGTH = 2'd2;

  localparam logic CMD_QUERY = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  localparam logic MODE_SPATIAL = 1'b0;
  localparam logic MODE_TEMPORAL = 1'b1;

  localparam logic [7:0] RUN_THRESHOLD_RESET = 8'd6;
  localparam logic [6:0] MISS_RATE_LIMIT_RESET = 7'd10;
  localparam logic [7:0] PHASE_LENGTH_RESET = 8'd128;
  localparam logic [7:0] PERCENT = 8'd100;
  localparam logic [3:0] REUSE_MAX = 4'd15;
  localparam logic [3:0] REUSE_BONUS = 4'd2;
  localparam logic [7:0] SCORE_MAX = 8'd255;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic [7:0] run_threshold;
    logic [6:0] miss_rate_limit;
    logic [7:0] phase_length;
  } cfg_t;

  typedef struct packed {
    logic                                  mode;
    logic [63:0]                           last_addr;
    logic [63:0]                           prev_stride;
    logic [7:0]                            stride_run;
    logic [TALLY_W-1:0]                    hit_tally;
    logic [TALLY_W-1:0]                    miss_tally;
    logic [PTR_W-1:0]                      pc_oldest;
    logic [PC_HISTORY_DEPTH-1:0][63:0]     pc_hist;
    logic [NUM_WAYS-1:0][63:0]             line_addr;
    logic [NUM_WAYS-1:0][3:0]              line_reuse;
    logic [NUM_WAYS-1:0][7:0]              line_stride;
  } set_row_t;

  typedef struct packed {
    logic in_stall;
    logic mem_re;
    logic mem_we;
    logic out_load;
    logic clear_we;
  } ctrl_t;

endpackage

>>> rtl/srar_row_mem.sv
// Synchronous set-row memory with one write port and one registered read port.
module srar_row_mem (
  input  logic                       clk,
  input  logic                       we,
  input  logic [srar_pkg::SET_W-1:0] waddr,
  input  srar_pkg::set_row_t         wdata,
  input  logic                       re,
  input  logic [srar_pkg::SET_W-1:0] raddr,
  output srar_pkg::set_row_t         rdata
);

  srar_pkg::set_row_t mem [srar_pkg::NUM_SETS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/srar_victim.sv
// Victim selection: lowest-indexed way with the smallest score for the set's mode.
module srar_victim (
  input  srar_pkg::set_row_t         row,
  output logic [srar_pkg::WAY_W-1:0] victim_way,
  output logic                       victim_mode
);

  localparam int LVLS = srar_pkg::WAY_W;
  localparam int WP2 = 1 << LVLS;

  logic [8:0]                 sc [WP2];
  logic [srar_pkg::WAY_W-1:0] ix [WP2];

  always_comb begin
    for (int i = 0; i < WP2; i++) begin
      if (i < srar_pkg::NUM_WAYS) begin
        if (row.mode == srar_pkg::MODE_TEMPORAL) begin
          sc[i] = {5'd0, row.line_reuse[i]};
        end else begin
          sc[i] = {1'b0, row.line_stride[i]};
        end
      end else begin
        sc[i] = 9'h100;
      end
      ix[i] = srar_pkg::WAY_W'(i);
    end
    for (int l = 0; l < LVLS; l++) begin
      for (int k = 0; k < (WP2 >> (l + 1)); k++) begin
        if (sc[k * (2 << l) + (1 << l)] < sc[k * (2 << l)]) begin
          sc[k * (2 << l)] = sc[k * (2 << l) + (1 << l)];
          ix[k * (2 << l)] = ix[k * (2 << l) + (1 << l)];
        end
      end
    end
    victim_way = ix[0];
    victim_mode = row.mode;
  end

endmodule

>>> rtl/srar_update.sv
// Access update: tallies, stride tracking, line scores, PC history and mode choice.
module srar_update (
  input  srar_pkg::set_row_t         row,
  input  srar_pkg::cfg_t             cfg,
  input  logic [srar_pkg::WAY_W-1:0] way,
  input  logic [63:0]                addr,
  input  logic [63:0]                pc,
  input  logic                       hit,
  output srar_pkg::set_row_t         row_next
);

  logic [srar_pkg::TALLY_W-1:0] hit_n;
  logic [srar_pkg::TALLY_W-1:0] miss_n;
  logic [srar_pkg::TALLY_W:0]   total;
  logic [63:0]                  stride;
  logic [63:0]                  line_delta;
  logic                         run_match;
  logic                         line_match;
  logic                         seen;
  logic [7:0]                   run_n;
  logic [4:0]                   reuse_sum;
  logic [15:0]                  miss_scaled;
  logic [16:0]                  limit_scaled;
  logic                         rate_ok;
  logic [7:0]                   cur_stride;
  logic [3:0]                   cur_reuse;

  always_comb begin
    row_next = row;
    hit_n = row.hit_tally + srar_pkg::TALLY_W'(hit);
    miss_n = row.miss_tally + srar_pkg::TALLY_W'(!hit);
    total = {1'b0, hit_n} + {1'b0, miss_n};

    stride = (row.last_addr != 64'd0) ? addr - row.last_addr : 64'd0;
    run_match = (stride != 64'd0) && (stride == row.prev_stride);
    if (run_match) begin
      run_n = (row.stride_run < srar_pkg::SCORE_MAX) ? row.stride_run + 8'd1 : row.stride_run;
    end else begin
      run_n = (row.stride_run > 8'd0) ? row.stride_run - 8'd1 : 8'd0;
    end

    line_delta = row.line_addr[way] - addr;
    line_match = (stride != 64'd0) && (stride == line_delta);
    cur_stride = row.line_stride[way];
    if (line_match) begin
      row_next.line_stride[way] = (cur_stride < srar_pkg::SCORE_MAX) ? cur_stride + 8'd1
                                                                      : cur_stride;
    end else begin
      row_next.line_stride[way] = (cur_stride > 8'd0) ? cur_stride - 8'd1 : 8'd0;
    end
    row_next.line_addr[way] = addr;

    seen = 1'b0;
    for (int i = 0; i < srar_pkg::PC_HISTORY_DEPTH; i++) begin
      if (row.pc_hist[i] == pc) begin
        seen = 1'b1;
      end
    end
    cur_reuse = row.line_reuse[way];
    reuse_sum = {1'b0, cur_reuse} + {1'b0, srar_pkg::REUSE_BONUS};
    if (seen) begin
      row_next.line_reuse[way] = (reuse_sum > {1'b0, srar_pkg::REUSE_MAX}) ? srar_pkg::REUSE_MAX
                                                                           : reuse_sum[3:0];
    end else begin
      row_next.line_reuse[way] = (cur_reuse > 4'd0) ? cur_reuse - 4'd1 : 4'd0;
    end
    row_next.pc_hist[row.pc_oldest] = pc;
    if (row.pc_oldest == srar_pkg::PTR_W'(srar_pkg::PC_HISTORY_DEPTH - 1)) begin
      row_next.pc_oldest = '0;
    end else begin
      row_next.pc_oldest = row.pc_oldest + srar_pkg::PTR_W'(1);
    end

    // The integer miss percentage is below the limit exactly when 100 * miss < limit * total.
    miss_scaled = 16'(miss_n) * 16'(srar_pkg::PERCENT);
    limit_scaled = 17'(cfg.miss_rate_limit) * 17'(total);
    rate_ok = {1'b0, miss_scaled} < limit_scaled;

    row_next.mode = (run_n >= cfg.run_threshold && rate_ok) ? srar_pkg::MODE_SPATIAL
                                                           : srar_pkg::MODE_TEMPORAL;
    row_next.last_addr = addr;
    row_next.prev_stride = stride;

    if (total > {2'b00, cfg.phase_length}) begin
      row_next.stride_run = 8'd0;
      row_next.hit_tally = '0;
      row_next.miss_tally = '0;
    end else begin
      row_next.stride_run = run_n;
      row_next.hit_tally = hit_n;
      row_next.miss_tally = miss_n;
    end
  end

endmodule

>>> rtl/stride_reuse_adaptive_replacement.sv
// Top level of the stride/reuse adaptive replacement block.
// Each beat is read and then executed: the set's row, holding its mode, stride and tally state, its
// PC history and all per-way scores, is read from a synchronous memory in the accept
// cycle, and in the next cycle the row is updated and written back or the victim is
// chosen and loaded into the output register. The input is stalled during the execution
// state, and a query also waits there while an earlier result is still held. After reset
// the block clears all 2048 sets of the row memory, one set per cycle, before it takes its
// first beat; configuration writes are taken at any time.
module stride_reuse_adaptive_replacement (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [srar_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [srar_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          cmd,
  input  logic [10:0]                   set_index,
  input  logic [3:0]                    way,
  input  logic [63:0]                   addr,
  input  logic [63:0]                   pc,
  input  logic                          hit,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [3:0]                    victim_way,
  output logic                          victim_mode
);

  srar_pkg::state_t   state;
  srar_pkg::state_t   state_next;
  srar_pkg::ctrl_t    ctrl;
  srar_pkg::cfg_t     cfg;
  srar_pkg::set_row_t rd_row;
  srar_pkg::set_row_t upd_row;
  srar_pkg::set_row_t wr_row;

  logic [srar_pkg::SET_W-1:0] clear_cnt;
  logic [srar_pkg::SET_W-1:0] set_q;
  logic [srar_pkg::SET_W-1:0] wr_addr;
  logic [srar_pkg::WAY_W-1:0] way_q;
  logic [srar_pkg::WAY_W-1:0] pick_way;
  logic                       pick_mode;
  logic                       cmd_q;
  logic [63:0]                addr_q;
  logic [63:0]                pc_q;
  logic                       hit_q;
  logic                       in_fire;
  logic                       out_free;

  assign in_fire = in_valid && !ctrl.in_stall;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = ctrl.in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.run_threshold <= srar_pkg::RUN_THRESHOLD_RESET;
      cfg.miss_rate_limit <= srar_pkg::MISS_RATE_LIMIT_RESET;
      cfg.phase_length <= srar_pkg::PHASE_LENGTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        srar_pkg::CFG_RUN_THRESHOLD:   cfg.run_threshold <= cfg_data;
        srar_pkg::CFG_MISS_RATE_LIMIT: cfg.miss_rate_limit <= cfg_data[6:0];
        srar_pkg::CFG_PHASE_LENGTH:    cfg.phase_length <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srar_pkg::ST_CLEAR;
      clear_cnt <= '0;
    end else begin
      state <= state_next;
      if (ctrl.clear_we) begin
        clear_cnt <= clear_cnt + srar_pkg::SET_W'(1);
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      srar_pkg::ST_CLEAR: begin
        if (clear_cnt == srar_pkg::SET_W'(srar_pkg::NUM_SETS - 1)) begin
          state_next = srar_pkg::ST_IDLE;
        end
      end
      srar_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = srar_pkg::ST_EXEC;
        end
      end
      srar_pkg::ST_EXEC: begin
        if (cmd_q == srar_pkg::CMD_UPDATE || out_free) begin
          state_next = srar_pkg::ST_IDLE;
        end
      end
      default: state_next = srar_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    ctrl = '0;
    unique case (state)
      srar_pkg::ST_CLEAR: begin
        ctrl.in_stall = 1'b1;
        ctrl.clear_we = 1'b1;
        ctrl.mem_we = 1'b1;
      end
      srar_pkg::ST_IDLE: begin
        ctrl.mem_re = in_valid;
      end
      srar_pkg::ST_EXEC: begin
        ctrl.in_stall = 1'b1;
        ctrl.mem_we = (cmd_q == srar_pkg::CMD_UPDATE);
        ctrl.out_load = (cmd_q == srar_pkg::CMD_QUERY) && out_free;
      end
      default: ctrl.in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_q <= cmd;
      set_q <= set_index[srar_pkg::SET_W-1:0];
      way_q <= way[srar_pkg::WAY_W-1:0];
      addr_q <= addr;
      pc_q <= pc;
      hit_q <= hit;
    end
  end

  assign wr_row = (state == srar_pkg::ST_CLEAR) ? '0 : upd_row;
  assign wr_addr = (state == srar_pkg::ST_CLEAR) ? clear_cnt : set_q;

  srar_row_mem u_mem (
    .clk   (clk),
    .we    (ctrl.mem_we),
    .waddr (wr_addr),
    .wdata (wr_row),
    .re    (ctrl.mem_re),
    .raddr (set_index[srar_pkg::SET_W-1:0]),
    .rdata (rd_row)
  );

  srar_update u_update (
    .row      (rd_row),
    .cfg      (cfg),
    .way      (way_q),
    .addr     (addr_q),
    .pc       (pc_q),
    .hit      (hit_q),
    .row_next (upd_row)
  );

  srar_victim u_victim (
    .row         (rd_row),
    .victim_way  (pick_way),
    .victim_mode (pick_mode)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      victim_way <= 4'(pick_way);
      victim_mode <= pick_mode;
    end
  end

  a_fire_to_exec: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> state == srar_pkg::ST_EXEC)
    else $error("accepted beat did not move to execution");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    !(ctrl.mem_we && ctrl.mem_re))
    else $error("row memory read and written in the same cycle");

  a_result_from_query: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == srar_pkg::ST_EXEC && cmd_q == srar_pkg::CMD_QUERY))
    else $error("result appeared without a query");

  a_held_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(victim_way) && $stable(victim_mode))
    else $error("held result changed");

endmodule

>>> bench/stride_reuse_adaptive_replacement_tb.sv
// Self-checking testbench for the stride/reuse adaptive replacement block.
`timescale 1ns / 100ps

module stride_reuse_adaptive_replacement_tb;

  typedef struct {
    logic [3:0] way;
    logic       mode;
  } victim_t;

  class victim_tracker;
    bit            set_mode[srar_pkg::NUM_SETS];
    bit [63:0]     last_addr[srar_pkg::NUM_SETS];
    bit [63:0]     prev_stride[srar_pkg::NUM_SETS];
    int            stride_run[srar_pkg::NUM_SETS];
    int            hits[srar_pkg::NUM_SETS];
    int            misses[srar_pkg::NUM_SETS];
    bit [63:0]     pc_hist[srar_pkg::NUM_SETS][srar_pkg::PC_HISTORY_DEPTH];
    int            pc_oldest[srar_pkg::NUM_SETS];
    bit [63:0]     line_addr[srar_pkg::NUM_SETS][srar_pkg::NUM_WAYS];
    int            reuse[srar_pkg::NUM_SETS][srar_pkg::NUM_WAYS];
    int            stride_score[srar_pkg::NUM_SETS][srar_pkg::NUM_WAYS];
    int            confidence = 6;
    int            rate_limit = 10;
    int            phase_len = 128;
    victim_t       pending[$];
    int            errors;

    function void write_reg(logic [srar_pkg::CFG_IDX_W-1:0] idx,
                            logic [srar_pkg::CFG_W-1:0] data);
      case (idx)
        srar_pkg::CFG_RUN_THRESHOLD: confidence = data;
        srar_pkg::CFG_MISS_RATE_LIMIT: rate_limit = data[6:0];
        srar_pkg::CFG_PHASE_LENGTH: phase_len = data;
        default: ;
      endcase
    endfunction

    function void note_beat(logic c, logic [10:0] s, logic [3:0] w, logic [63:0] a,
                            logic [63:0] p, logic h);
      victim_t v;
      bit [63:0] stride;
      bit seen;
      int total, rate, best;
      if (c == srar_pkg::CMD_QUERY) begin
        best = 0;
        for (int i = 1; i < srar_pkg::NUM_WAYS; i++) begin
          if (set_mode[s] == srar_pkg::MODE_TEMPORAL ? reuse[s][i] < reuse[s][best]
                                : stride_score[s][i] < stride_score[s][best])
            best = i;
        end
        v.way = 4'(best);
        v.mode = set_mode[s];
        pending.insert(pending.size(), v);
        return;
      end
      if (h) hits[s]++;
      else misses[s]++;
      stride = (last_addr[s] != 0) ? a - last_addr[s] : 64'd0;
      last_addr[s] = a;
      if (stride != 0 && stride == prev_stride[s]) begin
        if (stride_run[s] < 255) stride_run[s]++;
      end else if (stride_run[s] > 0) begin
        stride_run[s]--;
      end
      prev_stride[s] = stride;
      if (stride != 0 && stride == line_addr[s][w] - a) begin
        if (stride_score[s][w] < 255) stride_score[s][w]++;
      end else if (stride_score[s][w] > 0) begin
        stride_score[s][w]--;
      end
      line_addr[s][w] = a;
      seen = 0;
      for (int i = 0; i < srar_pkg::PC_HISTORY_DEPTH; i++)
        if (pc_hist[s][i] == p) seen = 1;
      if (seen) begin
        reuse[s][w] = (reuse[s][w] + 2 > 15) ? 15 : reuse[s][w] + 2;
      end else if (reuse[s][w] > 0) begin
        reuse[s][w]--;
      end
      pc_hist[s][pc_oldest[s]] = p;
      pc_oldest[s] = (pc_oldest[s] + 1) % srar_pkg::PC_HISTORY_DEPTH;
      total = hits[s] + misses[s];
      rate = (total > 0) ? (100 * misses[s]) / total : 0;
      set_mode[s] = (stride_run[s] >= confidence && rate < rate_limit) ? srar_pkg::MODE_SPATIAL
                                                                       : srar_pkg::MODE_TEMPORAL;
      if (total > phase_len) begin
        stride_run[s] = 0;
        hits[s] = 0;
        misses[s] = 0;
      end
    endfunction

    function void check_result(logic [3:0] w, logic m);
      victim_t v;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result way=%0d mode=%0d", $time, w, m);
        errors++;
        return;
      end
      v = pending.pop_front();
      if (w !== v.way) begin
        $display("%0t: victim_way expected %0d actual %0d", $time, v.way, w);
        errors++;
      end
      if (m !== v.mode) begin
        $display("%0t: victim_mode expected %0d actual %0d", $time, v.mode, m);
        errors++;
      end
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic [srar_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [srar_pkg::CFG_W-1:0]     cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic                           cmd = 1'b0;
  logic [10:0]                    set_index = '0;
  logic [3:0]                     way = '0;
  logic [63:0]                    addr = '0;
  logic [63:0]                    pc = '0;
  logic                           hit = 1'b0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [3:0]                     victim_way;
  logic                           victim_mode;

  victim_tracker tracker = new();
  bit            calm;
  bit            hold_req;
  int            quiet;
  int            item_count;
  logic [63:0]   pc_pool[8];
  logic [10:0]   set_pool[6] = '{11'd0, 11'd1, 11'd2, 11'd1024, 11'd2046, 11'd2047};

  stride_reuse_adaptive_replacement dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .set_index(set_index), .way(way), .addr(addr), .pc(pc), .hit(hit),
    .out_valid(out_valid), .out_stall(out_stall),
    .victim_way(victim_way), .victim_mode(victim_mode)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_beat(logic c, logic [10:0] s, logic [3:0] w, logic [63:0] a,
                           logic [63:0] p, logic h);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    set_index <= s;
    way <= w;
    addr <= a;
    pc <= p;
    hit <= h;
    do @(posedge clk); while (in_stall);
    tracker.note_beat(c, s, w, a, p, h);
    item_count++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_regs(int conf, int lim, int plen);
    cfg_we <= 1'b1;
    cfg_index <= srar_pkg::CFG_RUN_THRESHOLD;
    cfg_data <= srar_pkg::CFG_W'(conf);
    @(posedge clk);
    cfg_index <= srar_pkg::CFG_MISS_RATE_LIMIT;
    cfg_data <= srar_pkg::CFG_W'(lim);
    @(posedge clk);
    cfg_index <= srar_pkg::CFG_PHASE_LENGTH;
    cfg_data <= srar_pkg::CFG_W'(plen);
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.write_reg(srar_pkg::CFG_RUN_THRESHOLD, srar_pkg::CFG_W'(conf));
    tracker.write_reg(srar_pkg::CFG_MISS_RATE_LIMIT, srar_pkg::CFG_W'(lim));
    tracker.write_reg(srar_pkg::CFG_PHASE_LENGTH, srar_pkg::CFG_W'(plen));
  endtask

  function automatic logic [10:0] pick_set();
    return ($urandom_range(0, 9) == 0) ? 11'($urandom) : set_pool[$urandom_range(0, 5)];
  endfunction

  task automatic random_phase(int count);
    logic [10:0] s;
    logic [63:0] base, step;
    int len, period, stop;
    stop = item_count + count;
    while (item_count < stop) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          s = pick_set();
          base = rand64();
          case ($urandom_range(0, 4))
            0: step = 64'd64;
            1: step = -64'd128;
            2: step = 64'h8000_0000_0000_0000;
            3: step = 64'($urandom_range(1, 16));
            default: step = rand64();
          endcase
          len = $urandom_range(3, 14);
          period = $urandom_range(1, 4);
          for (int i = 0; i < len; i++) begin
            send_beat(srar_pkg::CMD_UPDATE, s, 4'(i % period + (s & 3)), base + i * step,
                      pc_pool[$urandom_range(0, 7)], $urandom_range(0, 7) != 0);
            if ($urandom_range(0, 3) == 0)
              send_beat(srar_pkg::CMD_QUERY, s, 4'($urandom), rand64(), rand64(),
                        1'($urandom));
          end
        end
        6, 7: send_beat(srar_pkg::CMD_QUERY, pick_set(), 4'($urandom), rand64(), rand64(),
                        1'($urandom));
        default: send_beat(srar_pkg::CMD_UPDATE, pick_set(), 4'($urandom), rand64(),
                           ($urandom_range(0, 1) == 0) ? rand64() : pc_pool[$urandom_range(0, 7)],
                           1'($urandom));
      endcase
    end
  endtask

  initial begin
    int gap, hold;
    bit held;
    gap = 0;
    hold = 0;
    held = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) tracker.check_result(victim_way, victim_mode);
      if (hold_req && !held) begin
        held = 1;
        hold = 300;
      end
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else if (gap > 0) begin
        gap--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        gap = $urandom_range(1, 18) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
      if (quiet >= 8000) begin
        $display("stride_reuse_adaptive_replacement_tb: errors");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < 8; i++) pc_pool[i] = (i == 0) ? 64'd0 : rand64();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    write_regs(6, 10, 128);

    send_beat(srar_pkg::CMD_QUERY, 11'd0, 4'd0, 64'd0, 64'd0, 1'b0);
    send_beat(srar_pkg::CMD_UPDATE, 11'd2047, 4'd15, '1, 64'd0, 1'b1);
    send_beat(srar_pkg::CMD_UPDATE, 11'd2047, 4'd15, 64'd0, '1, 1'b0);
    send_beat(srar_pkg::CMD_UPDATE, 11'd2047, 4'd0, 64'd5, '1, 1'b0);
    send_beat(srar_pkg::CMD_QUERY, 11'd2047, 4'd15, '1, '1, 1'b1);
    for (int i = 0; i < 10; i++)
      send_beat(srar_pkg::CMD_UPDATE, 11'd5, 4'(i % 3), 64'd100 + i * 64, 64'h40 + (i % 2),
                1'b1);
    send_beat(srar_pkg::CMD_QUERY, 11'd5, 4'd0, 64'd0, 64'd0, 1'b0);
    for (int i = 0; i < 4; i++)
      send_beat(srar_pkg::CMD_UPDATE, 11'd6, 4'(i % 2), 64'h8000_0000_0000_0000 * i + 1,
                64'd7, 1'b0);
    send_beat(srar_pkg::CMD_QUERY, 11'd6, 4'd0, 64'd0, 64'd0, 1'b0);
    drain();

    write_regs(0, 127, 0);
    random_phase(220);
    drain();

    write_regs(255, 0, 255);
    hold_req = 1;
    random_phase(220);
    drain();

    write_regs(2, 60, 5);
    random_phase(220);
    drain();

    write_regs(1, 101, 1);
    random_phase(200);
    drain();

    write_regs(6, 10, 128);
    calm = 1;
    random_phase(200);
    drain();

    if (tracker.errors == 0) begin
      $display("stride_reuse_adaptive_replacement_tb: clean");
    end else begin
      $display("stride_reuse_adaptive_replacement_tb: errors");
    end
    $finish;
  end

endmodule
